// ===== src/dfa_pkg.sv =====
// Shared types, constants and fork helpers for the dining fork arbiter.
package dfa_pkg;

  localparam int MAX_SEATS = 8;
  localparam int SEAT_W    = $clog2(MAX_SEATS);
  localparam int CNT_W     = $clog2(MAX_SEATS + 1);
  localparam int CFG_W     = 4;
  localparam logic [CFG_W-1:0] SEATS_RST = CFG_W'(8);

  // command queue between front and back
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  // result queue at the output
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

  // request kinds
  localparam logic REQ_ACQUIRE = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  typedef logic [SEAT_W-1:0]    seat_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [MAX_SEATS-1:0] fork_vec_t;

  typedef struct packed {
    logic  req_type;
    seat_t seat;
  } in_req_t;

  typedef struct packed {
    seat_t seat_out;
    logic  granted;
    logic  last;
  } out_res_t;

  typedef struct packed {
    logic  rel;
    seat_t seat;
  } cmd_t;

  // ring size with out-of-range register values pinned to the legal range
  function automatic cnt_t ring_clamp(input logic [CFG_W-1:0] v);
    cnt_t r;
    if (v < CFG_W'(2)) begin
      r = CNT_W'(2);
    end else if (CNT_W'(v) > CNT_W'(MAX_SEATS)) begin
      r = CNT_W'(MAX_SEATS);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

  // the seat's own fork and its right neighbor's, wrapping at the ring size
  function automatic fork_vec_t fork_pair(input seat_t s, input cnt_t n);
    cnt_t      nx;
    seat_t     rt;
    fork_vec_t p;
    nx = CNT_W'(s) + CNT_W'(1);
    rt = (nx == n) ? '0 : nx[SEAT_W-1:0];
    p = '0;
    p[s]  = 1'b1;
    p[rt] = 1'b1;
    return p;
  endfunction

  // one free bit for each fork inside the ring
  function automatic fork_vec_t all_free(input cnt_t n);
    fork_vec_t m;
    for (int i = 0; i < MAX_SEATS; i++) begin
      m[i] = (CNT_W'(i) < n);
    end
    return m;
  endfunction

endpackage

// ===== src/dining_fork_arbiter_core.sv =====
// A request is stored in the command queue, decided by the back end, then stored in the result queue before it shows.
// The back end takes one request per cycle while the result queue has room; a release holds it
//   for a scan of the wait list (up to 8 entries), one entry examined per cycle while the result queue has room.
// A release grant is sent once the next grant is found; the final one goes out at scan end.
// Reset (synchronous, rst_n low): ring of 8 seats, every fork free, wait list and queues empty.
// A register write frees every fork and empties the wait list; no clearing pass is needed.
module dining_fork_arbiter_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  input  dfa_pkg::in_req_t           in_req,
  output logic                       in_full,
  output logic                       out_empty,
  input  logic                       out_pop,
  output dfa_pkg::out_res_t          out_res,
  input  logic                       cfg_we,
  input  logic [dfa_pkg::CFG_W-1:0]  cfg_wdata
);
  import dfa_pkg::*;

  cnt_t     ring;
  logic     cmd_vld;
  cmd_t     cmd;
  logic     cmd_pop;
  logic     res_push;
  out_res_t res;
  logic     res_full;

  // accept and classify requests
  dfa_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_req  (in_req),
    .in_full (in_full),
    .ring    (ring),
    .cmd_vld (cmd_vld),
    .cmd     (cmd),
    .cmd_pop (cmd_pop)
  );

  // fork bookkeeping and release scan
  dfa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ring      (ring),
    .cmd_vld   (cmd_vld),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full)
  );

  // results wait here for the consumer
  dfa_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res),
    .full  (res_full),
    .empty (out_empty),
    .pop   (out_pop),
    .dout  (out_res)
  );

endmodule

// ===== src/dfa_front.sv =====
// Front end: takes requests, drops seats outside the ring, queues commands.
module dfa_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  input  dfa_pkg::in_req_t in_req,
  output logic            in_full,
  input  dfa_pkg::cnt_t   ring,
  output logic            cmd_vld,
  output dfa_pkg::cmd_t   cmd,
  input  logic            cmd_pop
);
  import dfa_pkg::*;

  cmd_t               q_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] rd_r, rd_nxt;
  logic [CMDQ_AW-1:0] wr_r, wr_nxt;
  logic [CMDQ_CW-1:0] cnt_r, cnt_nxt;
  logic               accept;
  logic               keep;
  logic               do_pop;
  cmd_t               new_cmd;

  // classify: a seat outside the ring is taken and dropped
  assign in_full = (cnt_r == CMDQ_CW'(CMDQ_DEPTH));
  assign accept  = in_push && !in_full;
  assign keep    = accept && (CNT_W'(in_req.seat) < ring);
  assign new_cmd = '{rel: (in_req.req_type == REQ_RELEASE), seat: in_req.seat};

  assign cmd_vld = (cnt_r != '0);
  assign cmd     = q_r[rd_r];
  assign do_pop  = cmd_pop && cmd_vld;

  // queue pointers
  always_comb begin
    rd_nxt  = do_pop ? rd_r + CMDQ_AW'(1) : rd_r;
    wr_nxt  = keep ? wr_r + CMDQ_AW'(1) : wr_r;
    cnt_nxt = cnt_r + CMDQ_CW'(keep) - CMDQ_CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= '0;
      wr_r  <= '0;
      cnt_r <= '0;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (keep) begin
      q_r[wr_r] <= new_cmd;
    end
  end

endmodule

// ===== src/dfa_back.sv =====
// Back end: fork state, wait list, grant decisions and the release scan.
module dfa_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [dfa_pkg::CFG_W-1:0]  cfg_wdata,
  output dfa_pkg::cnt_t              ring,
  input  logic                       cmd_vld,
  input  dfa_pkg::cmd_t              cmd,
  output logic                       cmd_pop,
  output logic                       res_push,
  output dfa_pkg::out_res_t          res,
  input  logic                       res_full
);
  import dfa_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic [CFG_W-1:0] seats_r;
  fork_vec_t        fork_r, fork_nxt;
  fork_vec_t        waiting_r, waiting_nxt;
  seat_t            wlist_r [MAX_SEATS];
  cnt_t             wcount_r, wcount_nxt;
  logic             state_r, state_nxt;
  cnt_t             idx_r, idx_nxt;
  cnt_t             kept_r, kept_nxt;
  logic             hold_vld_r, hold_vld_nxt;
  seat_t            hold_seat_r, hold_seat_nxt;

  logic             wl_we;
  seat_t            wl_addr;
  seat_t            wl_data;
  fork_vec_t        cmd_pair;
  seat_t            ent;
  fork_vec_t        ent_pair;

  assign ring     = ring_clamp(seats_r);
  assign cmd_pair = fork_pair(cmd.seat, ring);
  assign ent      = wlist_r[idx_r[SEAT_W-1:0]];
  assign ent_pair = fork_pair(ent, ring);

  // request handling and one wait-list entry per cycle during a scan, while the result queue has room
  always_comb begin
    fork_nxt      = fork_r;
    waiting_nxt   = waiting_r;
    wcount_nxt    = wcount_r;
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    kept_nxt      = kept_r;
    hold_vld_nxt  = hold_vld_r;
    hold_seat_nxt = hold_seat_r;
    cmd_pop       = 1'b0;
    res_push      = 1'b0;
    res           = '0;
    wl_we         = 1'b0;
    wl_addr       = '0;
    wl_data       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_vld && !res_full) begin
          cmd_pop = 1'b1;
          if (!cmd.rel) begin
            res_push = 1'b1;
            if ((fork_r & cmd_pair) == cmd_pair) begin
              fork_nxt = fork_r & ~cmd_pair;
              res      = '{seat_out: cmd.seat, granted: 1'b1, last: 1'b1};
            end else begin
              // queue the seat once; a repeat just reports not granted
              if (!waiting_r[cmd.seat] && (wcount_r < CNT_W'(MAX_SEATS))) begin
                wl_we                 = 1'b1;
                wl_addr               = wcount_r[SEAT_W-1:0];
                wl_data               = cmd.seat;
                wcount_nxt            = wcount_r + CNT_W'(1);
                waiting_nxt[cmd.seat] = 1'b1;
              end
              res = '{seat_out: cmd.seat, granted: 1'b0, last: 1'b1};
            end
          end else begin
            fork_nxt     = fork_r | cmd_pair;
            idx_nxt      = '0;
            kept_nxt     = '0;
            hold_vld_nxt = 1'b0;
            state_nxt    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (!res_full) begin
          if (idx_r == wcount_r) begin
            // end of scan: compact count, flush the held grant as last
            wcount_nxt   = kept_r;
            hold_vld_nxt = 1'b0;
            state_nxt    = ST_IDLE;
            if (hold_vld_r) begin
              res_push = 1'b1;
              res      = '{seat_out: hold_seat_r, granted: 1'b1, last: 1'b1};
            end
          end else begin
            idx_nxt = idx_r + CNT_W'(1);
            if (CNT_W'(ent) >= ring) begin
              waiting_nxt[ent] = 1'b0;
            end else if ((fork_nxt & ent_pair) == ent_pair) begin
              fork_nxt         = fork_r & ~ent_pair;
              waiting_nxt[ent] = 1'b0;
              // a grant is held back until the next one is found so the final one can carry last
              if (hold_vld_r) begin
                res_push = 1'b1;
                res      = '{seat_out: hold_seat_r, granted: 1'b1, last: 1'b0};
              end
              hold_vld_nxt  = 1'b1;
              hold_seat_nxt = ent;
            end else begin
              wl_we    = 1'b1;
              wl_addr  = kept_r[SEAT_W-1:0];
              wl_data  = ent;
              kept_nxt = kept_r + CNT_W'(1);
            end
          end
        end
      end
    endcase
  end

  // state registers; a register write restarts the ring
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seats_r    <= SEATS_RST;
      fork_r     <= all_free(ring_clamp(SEATS_RST));
      waiting_r  <= '0;
      wcount_r   <= '0;
      state_r    <= ST_IDLE;
      idx_r      <= '0;
      kept_r     <= '0;
      hold_vld_r <= 1'b0;
    end else if (cfg_we) begin
      seats_r    <= cfg_wdata;
      fork_r     <= all_free(ring_clamp(cfg_wdata));
      waiting_r  <= '0;
      wcount_r   <= '0;
      state_r    <= ST_IDLE;
      idx_r      <= '0;
      kept_r     <= '0;
      hold_vld_r <= 1'b0;
    end else begin
      fork_r     <= fork_nxt;
      waiting_r  <= waiting_nxt;
      wcount_r   <= wcount_nxt;
      state_r    <= state_nxt;
      idx_r      <= idx_nxt;
      kept_r     <= kept_nxt;
      hold_vld_r <= hold_vld_nxt;
    end
  end

  // held grant seat
  always_ff @(posedge clk) begin
    hold_seat_r <= hold_seat_nxt;
  end

  // wait list entries
  always_ff @(posedge clk) begin
    if (wl_we) begin
      wlist_r[wl_addr] <= wl_data;
    end
  end

endmodule

// ===== src/dfa_outq.sv =====
// Result queue between the back end and the result ports.
module dfa_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  dfa_pkg::out_res_t  din,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output dfa_pkg::out_res_t  dout
);
  import dfa_pkg::*;

  out_res_t           q_r [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] rd_r;
  logic [OUTQ_AW-1:0] wr_r;
  logic [OUTQ_CW-1:0] cnt_r, cnt_nxt;
  logic               do_push;
  logic               do_pop;

  assign full    = (cnt_r == OUTQ_CW'(OUTQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = q_r[rd_r];
  assign cnt_nxt = cnt_r + OUTQ_CW'(do_push) - OUTQ_CW'(do_pop);

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= '0;
      wr_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_pop) begin
        rd_r <= rd_r + OUTQ_AW'(1);
      end
      if (do_push) begin
        wr_r <= wr_r + OUTQ_AW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_r] <= din;
    end
  end

endmodule

// ===== src/dfa_chk.sv =====
// Port-level checker for the arbiter core, bound to the top level.
module dfa_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_full,
  input logic                       out_empty,
  input logic                       out_pop,
  input dfa_pkg::out_res_t          out_res,
  input logic                       cfg_we
);

  // queues come out of reset empty
  a_rst_out_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_rst_in_open: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input side full after reset");

  // a seat that was queued only ever comes from a request, which is always last
  a_wait_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_res.granted) |-> out_res.last)
    else $error("queued-seat result without last");

  // a waiting result holds until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop && !cfg_we) |=> (!out_empty && $stable(out_res)))
    else $error("pending result changed before pop");

endmodule

bind dining_fork_arbiter_core dfa_chk u_dfa_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_res   (out_res),
  .cfg_we    (cfg_we)
);

// ===== sim/dining_fork_arbiter_core_test.sv =====
// Self-checking testbench for the dining fork arbiter: directed and random requests vs a predictor.
`timescale 1ns / 100ps

module dining_fork_arbiter_core_test;
  import dfa_pkg::*;

  localparam int IDLE_PCT       = 28;
  localparam int SETTLE_CYCLES  = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RAND_PER_PHASE = 8;
  localparam int NUM_PHASES     = 9;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_push   = 1'b0;
  in_req_t          in_req    = '0;
  logic             in_full;
  logic             out_empty;
  logic             out_pop   = 1'b0;
  out_res_t         out_res;
  logic             cfg_we    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // stimulus waiting for the driver, answers the arbiter still owes us
  in_req_t   pending[$];
  out_res_t  answers_due[$];

  // predictor state: fork map, FIFO of waiting seats, ring register
  fork_vec_t        forks_free;
  seat_t            waiters[$];
  logic [CFG_W-1:0] ring_reg;

  int errors      = 0;
  int idle_cycles = 0;
  bit no_gaps     = 1'b0;

  logic [CFG_W-1:0] ring_plan [NUM_PHASES] = '{
    CFG_W'(2), CFG_W'(15), CFG_W'(0), CFG_W'(3), CFG_W'(8),
    CFG_W'(6), CFG_W'(1), CFG_W'(9), CFG_W'(7)
  };

  dining_fork_arbiter_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_req    (in_req),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ring size, out-of-range register values pinned to 2..MAX_SEATS
  function automatic int ring_size();
    int n;
    n = int'(ring_reg);
    if (n < 2) n = 2;
    if (n > MAX_SEATS) n = MAX_SEATS;
    return n;
  endfunction

  // left and right fork of a seat
  function automatic fork_vec_t seat_forks(int s, int n);
    fork_vec_t m;
    m = '0;
    m[s] = 1'b1;
    m[(s + 1 == n) ? 0 : s + 1] = 1'b1;
    return m;
  endfunction

  // register write: new ring, all forks free, nobody waiting
  task automatic apply_ring(logic [CFG_W-1:0] v);
    ring_reg   = v;
    forks_free = '0;
    for (int i = 0; i < ring_size(); i++) forks_free[i] = 1'b1;
    waiters.delete();
  endtask

  // predict the answers for one accepted request
  task automatic arbitrate(in_req_t r);
    int        n;
    bit        present;
    fork_vec_t need;
    out_res_t  a;
    out_res_t  hits[$];
    seat_t     keep[$];
    n = ring_size();
    if (int'(r.seat) >= n) return;
    if (r.req_type == REQ_ACQUIRE) begin
      need       = seat_forks(r.seat, n);
      a.seat_out = r.seat;
      a.last     = 1'b1;
      if ((forks_free & need) == need) begin
        forks_free &= ~need;
        a.granted   = 1'b1;
      end else begin
        // a seat already waiting gets told again but is not queued twice
        present = 1'b0;
        foreach (waiters[i]) if (waiters[i] == r.seat) present = 1'b1;
        if (!present && waiters.size() < MAX_SEATS) waiters = {waiters, r.seat};
        a.granted = 1'b0;
      end
      answers_due = {answers_due, a};
    end else begin
      // release never checked against held grants; then scan oldest first
      forks_free |= seat_forks(r.seat, n);
      foreach (waiters[i]) begin
        if (int'(waiters[i]) >= n) continue;
        need = seat_forks(waiters[i], n);
        if ((forks_free & need) == need) begin
          forks_free &= ~need;
          a.seat_out  = waiters[i];
          a.granted   = 1'b1;
          a.last      = 1'b0;
          hits = {hits, a};
        end else begin
          keep = {keep, waiters[i]};
        end
      end
      waiters = keep;
      if (hits.size() > 0) hits[hits.size() - 1].last = 1'b1;
      foreach (hits[i]) answers_due = {answers_due, hits[i]};
    end
  endtask

  task automatic flag_mismatch(string msg);
    $display("%0t MISMATCH: %s", $realtime, msg);
    errors++;
  endtask

  // compare one popped answer with the oldest prediction
  task automatic check_answer(out_res_t got);
    out_res_t want;
    if (answers_due.size() == 0) begin
      flag_mismatch($sformatf("unexpected answer seat %0d granted %0d last %0d",
                              got.seat_out, got.granted, got.last));
    end else begin
      want = answers_due.pop_front();
      if (got.seat_out != want.seat_out)
        flag_mismatch($sformatf("seat_out %0d, predicted %0d", got.seat_out, want.seat_out));
      if (got.granted != want.granted)
        flag_mismatch($sformatf("seat %0d granted %0d, predicted %0d",
                                want.seat_out, got.granted, want.granted));
      if (got.last != want.last)
        flag_mismatch($sformatf("seat %0d last %0d, predicted %0d",
                                want.seat_out, got.last, want.last));
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) arbitrate(in_req);
      if (!(in_push && in_full)) begin
        if (pending.size() > 0 && (no_gaps || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_push <= 1'b1;
          in_req  <= pending.pop_front();
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // answer monitor with random back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) check_answer(out_res);
      out_pop <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // watchdog: too long without any handshake
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic queue_req(logic kind, int s);
    in_req_t r;
    r.req_type = kind;
    r.seat     = seat_t'(s);
    pending    = {pending, r};
  endtask

  // sampled mid-cycle so the driver's updates of this edge are visible
  task automatic wait_quiet();
    do @(negedge clk);
    while (pending.size() != 0 || in_push || answers_due.size() != 0);
  endtask

  // write the ring register once the arbiter has gone quiet
  task automatic write_ring(logic [CFG_W-1:0] v);
    wait_quiet();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_ring(v);
  endtask

  // mostly acquire/release pairs on seats we asked for, some noise
  task automatic random_phase(int count);
    int         n;
    int         r;
    int         s;
    logic       kind;
    logic [7:0] asked;
    n     = ring_size();
    asked = '0;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        kind = logic'($urandom_range(0, 1));
        s    = $urandom_range(0, 7);
      end else if (r < 50 && asked != '0) begin
        do s = $urandom_range(0, n - 1);
        while (!asked[s]);
        asked[s] = 1'b0;
        kind     = REQ_RELEASE;
      end else begin
        s        = $urandom_range(0, n - 1);
        asked[s] = 1'b1;
        kind     = REQ_ACQUIRE;
      end
      queue_req(kind, s);
    end
  endtask

  // test sequence
  initial begin
    apply_ring(SEATS_RST);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // full ring of eight
    write_ring(CFG_W'(8));
    queue_req(REQ_ACQUIRE, 0);   // granted
    queue_req(REQ_ACQUIRE, 1);   // fork 1 busy, waits
    queue_req(REQ_ACQUIRE, 1);   // already waiting, not queued again
    queue_req(REQ_ACQUIRE, 7);   // wrap fork 0 busy, waits
    queue_req(REQ_ACQUIRE, 3);   // granted
    queue_req(REQ_ACQUIRE, 2);   // waits
    queue_req(REQ_RELEASE, 0);   // scan grants 1 and 7, 2 stays
    queue_req(REQ_RELEASE, 5);   // release without a grant, nothing to hand out
    queue_req(REQ_RELEASE, 3);   // 2 still blocked by seat 1
    queue_req(REQ_RELEASE, 1);   // grants 2
    queue_req(REQ_ACQUIRE, 6);   // waits on fork 7
    queue_req(REQ_ACQUIRE, 5);   // granted
    queue_req(REQ_ACQUIRE, 4);   // waits
    queue_req(REQ_RELEASE, 2);
    queue_req(REQ_RELEASE, 7);
    queue_req(REQ_RELEASE, 5);   // grants 6 then 4
    queue_req(REQ_RELEASE, 6);
    queue_req(REQ_RELEASE, 4);
    queue_req(REQ_ACQUIRE, 0);
    queue_req(REQ_ACQUIRE, 1);   // waits
    queue_req(REQ_RELEASE, 1);   // waiting seat releases, then gets its own grant
    queue_req(REQ_RELEASE, 0);
    queue_req(REQ_RELEASE, 1);

    // smaller ring: seats past the end are ignored, seat 4 wraps to fork 0
    write_ring(CFG_W'(5));
    queue_req(REQ_ACQUIRE, 6);
    queue_req(REQ_RELEASE, 7);
    queue_req(REQ_ACQUIRE, 4);
    queue_req(REQ_ACQUIRE, 0);
    queue_req(REQ_RELEASE, 4);

    // random phases over ring sizes incl. out-of-range values
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_ring(ring_plan[p]);
      no_gaps = (p == 4) || (p == 5);
      random_phase(RAND_PER_PHASE);
    end

    wait_quiet();
    no_gaps = 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
